FILE: hdl/pfst_pkg.sv
package pfst_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    localparam int CMD_W    = 3;
    localparam int CID_W    = 31;
    localparam int IDX_W    = 3;
    localparam int FRAME_W  = 32;
    localparam int TIME_W   = 63;
    localparam int STAT_W   = 2;
    localparam int LEAD_W   = 32;
    localparam int VERD_W   = 2;
    localparam int STALE_W  = 32;
    localparam int WIN_W    = 31;
    localparam int SLACK_W  = 21;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_JOIN    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LEAVE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUBLISH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LEAD    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WAIT    = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_OWNED = 2'd2;

    localparam logic [VERD_W-1:0] V_ALONE   = 2'd0;
    localparam logic [VERD_W-1:0] V_FAR     = 2'd1;
    localparam logic [VERD_W-1:0] V_PROCEED = 2'd2;
    localparam logic [VERD_W-1:0] V_WAIT    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_STALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLACK = 2'd2;

    localparam logic [STALE_W-1:0] STALE_RST = 32'd1000000;
    localparam logic [WIN_W-1:0]   WIN_RST   = 31'd307200;
    localparam logic [SLACK_W-1:0] SLACK_RST = 21'd2048;

    localparam logic [FRAME_W-1:0] FRAME_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [CID_W-1:0]   owner;
        logic [TIME_W-1:0]  hb;
        logic [FRAME_W-1:0] frame;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hdl/pfst_ram.sv
module pfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/peer_frame_sync_table.sv
// Channel   Direction  Transfer on                  Contents
// s_axis    in         s_axis_tvalid & tready       one command
// m_axis    out        m_axis_tvalid & tready       one result per command
// cfg       in         cfg_valid & cfg_ready        register index and data
//
// Leave, publish and a refused command pass check and done, an unknown command only done,
// join scan, finish and done, lead query and wait check add check in front; the single
// read port of the slot memory walks the slots one per cycle. The next command is taken in
// the cycle after the result is loaded, while it may still wait on m_axis. Invalid slots
// read as zero. Reset clears control and the slot valid bits and presets the cfg registers.
module peer_frame_sync_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pfst_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // client_id, slot_index, frame_pos, now_us
    input  logic [pfst_pkg::CMD_W-1:0]        s_axis_tuser,  // cmd
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pfst_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // status, granted_slot, lead, verdict
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfst_pkg::STALE_W-1:0]      cfg_data
);

    import pfst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [STALE_W-1:0] stale_reg;
    logic [WIN_W-1:0]   win_reg;
    logic [SLACK_W-1:0] slack_reg;

    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [CID_W-1:0]   cid_reg, cid_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [TIME_W-1:0]  now_reg, now_next;

    logic [SLOT_COUNT-1:0] vld_reg, vld_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0]     ridx_reg;

    logic              match_reg, match_next;
    logic [SLOT_W-1:0] match_idx_reg, match_idx_next;
    logic              free_reg, free_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;
    logic [1:0]        peers_reg, peers_next;
    logic              far_reg, far_next;
    logic [FRAME_W-1:0] slow_reg, slow_next;

    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_slot_reg, res_slot_next;
    logic [LEAD_W-1:0] res_lead_reg, res_lead_next;
    logic [VERD_W-1:0] res_verd_reg, res_verd_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    entry_t             ram_wentry;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    entry_t             rd_entry;
    logic               in_xfer;
    logic signed [63:0] age;
    logic               live;
    logic signed [32:0] fdiff;
    logic [32:0]        fdist;
    logic               own_ok;
    logic signed [32:0] lead_diff;
    logic signed [33:0] slow_plus;

    pfst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign rd_entry = vld_reg[ridx_reg] ? entry_t'(ram_rdata) : '0;

    assign age   = $signed({1'b0, now_reg}) - $signed({1'b0, rd_entry.hb});
    assign live  = (rd_entry.hb != '0) && (age <= $signed({32'b0, stale_reg}));
    assign fdiff = $signed({rd_entry.frame[FRAME_W-1], rd_entry.frame})
                 - $signed({frame_reg[FRAME_W-1], frame_reg});
    assign fdist = fdiff[32] ? 33'(-fdiff) : 33'(fdiff);
    assign own_ok = (32'(slot_reg) < 32'(SLOT_COUNT)) && (rd_entry.owner == cid_reg);

    assign lead_diff = $signed({frame_reg[FRAME_W-1], frame_reg})
                     - $signed({slow_reg[FRAME_W-1], slow_reg});
    assign slow_plus = $signed({{2{slow_reg[FRAME_W-1]}}, slow_reg})
                     + $signed({13'b0, slack_reg});

    always_comb
    begin
        ram_raddr = '0;
        if (state_reg == S_IDLE)
        begin
            ram_raddr = SLOT_W'(s_axis_tdata[CID_W +: IDX_W]);
        end
        else if (state_reg == S_SCAN)
        begin
            ram_raddr = cnt_reg[SLOT_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        cid_next        = cid_reg;
        slot_next       = slot_reg;
        frame_next      = frame_reg;
        now_next        = now_reg;
        vld_next        = vld_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = 1'b0;
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        peers_next      = peers_reg;
        far_next        = far_reg;
        slow_next       = slow_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_lead_next   = res_lead_reg;
        res_verd_next   = res_verd_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = SLOT_W'(slot_reg);
        ram_wentry      = rd_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next        = s_axis_tuser;
                    cid_next        = s_axis_tdata[0 +: CID_W];
                    slot_next       = s_axis_tdata[CID_W +: IDX_W];
                    frame_next      = s_axis_tdata[CID_W + IDX_W +: FRAME_W];
                    now_next        = s_axis_tdata[CID_W + IDX_W + FRAME_W +: TIME_W];
                    res_status_next = ST_OK;
                    res_slot_next   = s_axis_tdata[CID_W +: IDX_W];
                    res_lead_next   = '0;
                    res_verd_next   = V_ALONE;
                    cnt_next        = '0;
                    match_next      = 1'b0;
                    free_next       = 1'b0;
                    peers_next      = '0;
                    far_next        = 1'b0;
                    slow_next       = FRAME_MAX;
                    if (s_axis_tuser == CMD_JOIN)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (s_axis_tuser <= CMD_WAIT)
                    begin
                        state_next = S_CHK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CHK:
            begin
                state_next = S_DONE;
                if (!own_ok)
                begin
                    res_status_next = ST_NOT_OWNED;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_LEAVE:
                        begin
                            ram_we        = 1'b1;
                            ram_wentry.hb = '0;
                        end
                        CMD_PUBLISH:
                        begin
                            ram_we           = 1'b1;
                            ram_wentry.hb    = now_reg;
                            ram_wentry.frame = frame_reg;
                        end
                        CMD_LEAD:
                        begin
                            state_next = S_SCAN;
                        end
                        CMD_WAIT:
                        begin
                            ram_we           = 1'b1;
                            ram_wentry.hb    = now_reg;
                            ram_wentry.frame = frame_reg;
                            state_next       = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                    if (ram_we)
                    begin
                        vld_next[ram_waddr] = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (cnt_reg < CNT_W'(SLOT_COUNT))
                begin
                    cnt_next     = cnt_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    if (rd_entry.owner == cid_reg && !match_reg)
                    begin
                        match_next     = 1'b1;
                        match_idx_next = ridx_reg;
                    end
                    if (!live && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = ridx_reg;
                    end
                    if (live)
                    begin
                        if (peers_reg != 2'd2)
                        begin
                            peers_next = peers_reg + 1'b1;
                        end
                        if (fdist > {2'b0, win_reg})
                        begin
                            far_next = 1'b1;
                        end
                        if ($signed(rd_entry.frame) < $signed(slow_reg))
                        begin
                            slow_next = rd_entry.frame;
                        end
                    end
                    if (cnt_reg == CNT_W'(SLOT_COUNT))
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                state_next = S_DONE;
                if (cmd_reg == CMD_JOIN)
                begin
                    if (match_reg || free_reg)
                    begin
                        ram_we           = 1'b1;
                        ram_waddr        = match_reg ? match_idx_reg : free_idx_reg;
                        ram_wentry.owner = cid_reg;
                        ram_wentry.hb    = now_reg;
                        ram_wentry.frame = '0;
                        vld_next[ram_waddr] = 1'b1;
                        res_slot_next    = IDX_W'(ram_waddr);
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                end
                else if (cmd_reg == CMD_WAIT && peers_reg < 2'd2)
                begin
                    res_verd_next = V_ALONE;
                end
                else if (far_reg)
                begin
                    res_verd_next = V_FAR;
                end
                else if (peers_reg < 2'd2)
                begin
                    res_verd_next = V_ALONE;
                end
                else
                begin
                    res_lead_next = (lead_diff > 33'sd0) ? lead_diff[LEAD_W-1:0] : '0;
                    res_verd_next = ($signed({{2{frame_reg[FRAME_W-1]}}, frame_reg})
                                     <= slow_plus) ? V_PROCEED : V_WAIT;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, res_verd_reg, res_lead_reg,
                                      res_slot_reg, res_status_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vld_reg       <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            stale_reg     <= STALE_RST;
            win_reg       <= WIN_RST;
            slack_reg     <= SLACK_RST;
        end
        else
        begin
            state_reg     <= state_next;
            vld_reg       <= vld_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_STALE: stale_reg <= cfg_data;
                    REG_WIN:   win_reg   <= cfg_data[WIN_W-1:0];
                    REG_SLACK: slack_reg <= cfg_data[SLACK_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        cid_reg        <= cid_next;
        slot_reg       <= slot_next;
        frame_reg      <= frame_next;
        now_reg        <= now_next;
        ridx_reg       <= ram_raddr;
        match_reg      <= match_next;
        match_idx_reg  <= match_idx_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
        peers_reg      <= peers_next;
        far_reg        <= far_next;
        slow_reg       <= slow_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_lead_reg   <= res_lead_next;
        res_verd_reg   <= res_verd_next;
        out_data_reg   <= out_data_next;
    end

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !rd_pend_reg)
        else $error("slot write while a scan read is in flight");

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> vld_reg[$past(ram_waddr)])
        else $error("written slot not marked valid");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg != S_IDLE)
        else $error("command transfer did not start work");

    a_fin_after_full_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |-> (cnt_reg == CNT_W'(SLOT_COUNT)) && !rd_pend_reg)
        else $error("scan finished before all slots were read");

endmodule
